// File: rtl/pdc_pkg.sv
package pdc_pkg;

    localparam int WORD_W     = 64;
    localparam int LIMB_W     = 32;
    localparam int HASH_LIMBS = 8;
    localparam int DIFF_LIMBS = 4;
    localparam int PROD_W     = 2 * LIMB_W;
    localparam int COLS       = HASH_LIMBS + DIFF_LIMBS;
    // a column holds up to eight limbs plus an incoming carry below 8
    localparam int CARRY_W    = 3;
    localparam int COL_W      = LIMB_W + CARRY_W;
    localparam int CHUNK      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DIFF_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_HIGH = 2'd1;

    typedef logic [LIMB_W-1:0]                               t_limb;
    typedef logic [CARRY_W-1:0]                              t_carry;
    typedef logic [HASH_LIMBS-1:0][DIFF_LIMBS-1:0][PROD_W-1:0] t_prods;
    typedef logic [COLS-1:0][COL_W-1:0]                      t_cols;
    typedef logic [CHUNK-1:0][COL_W-1:0]                     t_chunk;

    typedef struct packed {
        t_carry carry;
        logic   zero;
    } t_chunk_res;

    // Carry-propagate four columns; zero is set when all four result limbs are zero.
    function automatic t_chunk_res chunk_add(t_chunk c, t_carry cin);
        logic [COL_W-1:0] s;
        t_carry           cy;
        t_chunk_res       r;
        cy     = cin;
        r.zero = 1'b1;
        for (int k = 0; k < CHUNK; k++) begin
            s      = c[k] + COL_W'(cy);
            r.zero = r.zero & (s[LIMB_W-1:0] == '0);
            cy     = s[COL_W-1:LIMB_W];
        end
        r.carry = cy;
        return r;
    endfunction

endpackage

// File: rtl/pdc_mul_array.sv
module pdc_mul_array (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [pdc_pkg::WORD_W-1:0] i_hash_word0,
    input  logic [pdc_pkg::WORD_W-1:0] i_hash_word1,
    input  logic [pdc_pkg::WORD_W-1:0] i_hash_word2,
    input  logic [pdc_pkg::WORD_W-1:0] i_hash_word3,
    input  logic [pdc_pkg::WORD_W-1:0] i_diff_low,
    input  logic [pdc_pkg::WORD_W-1:0] i_diff_high,
    output logic                      o_valid,
    output pdc_pkg::t_prods           o_prods
);

    logic [pdc_pkg::HASH_LIMBS*pdc_pkg::LIMB_W-1:0] w_hash;
    logic [pdc_pkg::DIFF_LIMBS*pdc_pkg::LIMB_W-1:0] w_diff;
    logic                                         r_valid;
    pdc_pkg::t_prods                              r_prods;

    assign w_hash = {i_hash_word3, i_hash_word2, i_hash_word1, i_hash_word0};
    assign w_diff = {i_diff_high, i_diff_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // 32 independent 32x32 lanes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < pdc_pkg::HASH_LIMBS; i++) begin
                for (int j = 0; j < pdc_pkg::DIFF_LIMBS; j++) begin
                    r_prods[i][j] <=
                        pdc_pkg::PROD_W'(w_hash[i*pdc_pkg::LIMB_W +: pdc_pkg::LIMB_W]) *
                        pdc_pkg::PROD_W'(w_diff[j*pdc_pkg::LIMB_W +: pdc_pkg::LIMB_W]);
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_prods = r_prods;

endmodule

// File: rtl/pdc_col_sum.sv
module pdc_col_sum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  pdc_pkg::t_prods i_prods,
    output logic            o_valid,
    output pdc_pkg::t_cols  o_cols
);

    logic           r_valid;
    pdc_pkg::t_cols r_cols;
    pdc_pkg::t_cols n_cols;

    // low half of p[i][j] lands in column i+j, high half in column i+j+1
    always_comb begin
        n_cols = '0;
        for (int i = 0; i < pdc_pkg::HASH_LIMBS; i++) begin
            for (int j = 0; j < pdc_pkg::DIFF_LIMBS; j++) begin
                n_cols[i+j]   = n_cols[i+j] +
                    pdc_pkg::COL_W'(i_prods[i][j][pdc_pkg::LIMB_W-1:0]);
                n_cols[i+j+1] = n_cols[i+j+1] +
                    pdc_pkg::COL_W'(i_prods[i][j][pdc_pkg::PROD_W-1:pdc_pkg::LIMB_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cols <= n_cols;
        end
    end

    assign o_valid = r_valid;
    assign o_cols  = r_cols;

endmodule

// File: rtl/pdc_carry_pipe.sv
module pdc_carry_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pdc_pkg::t_cols i_cols,
    output logic           o_valid,
    output logic           o_meets_target
);

    // stage 1 resolves columns 0..3, stage 2 columns 4..7, stage 3 columns 8..11
    logic                                              r_valid1;
    logic                                              r_valid2;
    logic                                              r_valid3;
    pdc_pkg::t_carry                                   r_carry1;
    pdc_pkg::t_carry                                   r_carry2;
    logic [2*pdc_pkg::CHUNK-1:0][pdc_pkg::COL_W-1:0]   r_cols1;
    pdc_pkg::t_chunk                                   r_cols2;
    logic                                              r_meets;
    pdc_pkg::t_chunk_res                               n_res1;
    pdc_pkg::t_chunk_res                               n_res2;
    pdc_pkg::t_chunk_res                               n_res3;
    pdc_pkg::t_chunk                                   w_in_lo;
    pdc_pkg::t_chunk                                   w_mid;

    assign w_in_lo = i_cols[pdc_pkg::CHUNK-1:0];
    assign w_mid   = r_cols1[pdc_pkg::CHUNK-1:0];

    always_comb begin
        n_res1 = pdc_pkg::chunk_add(w_in_lo, '0);
        n_res2 = pdc_pkg::chunk_add(w_mid, r_carry1);
        n_res3 = pdc_pkg::chunk_add(r_cols2, r_carry2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry1 <= n_res1.carry;
            r_cols1  <= i_cols[pdc_pkg::COLS-1:pdc_pkg::CHUNK];
            r_carry2 <= n_res2.carry;
            r_cols2  <= r_cols1[2*pdc_pkg::CHUNK-1:pdc_pkg::CHUNK];
            // top 128 bits zero; carry out of the top column is always zero
            r_meets  <= n_res3.zero;
        end
    end

    assign o_valid        = r_valid3;
    assign o_meets_target = r_meets;

endmodule

// File: rtl/pow_difficulty_check.sv
// Proof-of-work difficulty check. Each transfer on the input channel carries one
// 256-bit hash as four 64-bit words, least significant word first. The block forms
// the full 384-bit product hash * difficulty and reports meets_target = 1 when its
// upper 128 bits are zero (product below 2^256); a zero difficulty always passes.
// The difficulty is written through the config port (index 0 = low 64 bits,
// index 1 = high 64 bits, both reset to 0; writes to other indexes are ignored)
// and must only change while no hash is in flight. Throughput is one hash per
// clock while the result channel does not stall; a result passes through five
// register stages: a stage of 32 parallel 32x32 multipliers, a column sum stage,
// and three carry-propagate stages of four 32-bit columns each. The pipeline
// advances as a whole whenever the output register is empty or being taken, so
// o_ready follows i_ready combinationally when the output is full.
module pow_difficulty_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // hash input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pdc_pkg::WORD_W-1:0]     i_hash_word0,
    input  logic [pdc_pkg::WORD_W-1:0]     i_hash_word1,
    input  logic [pdc_pkg::WORD_W-1:0]     i_hash_word2,
    input  logic [pdc_pkg::WORD_W-1:0]     i_hash_word3,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_meets_target
);

    logic [pdc_pkg::WORD_W-1:0] r_diff_low;
    logic [pdc_pkg::WORD_W-1:0] r_diff_high;
    logic                       w_en;
    logic                       w_mul_valid;
    pdc_pkg::t_prods            w_prods;
    logic                       w_col_valid;
    pdc_pkg::t_cols             w_cols;

    // Difficulty registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_low  <= '0;
            r_diff_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdc_pkg::REG_DIFF_LOW:  r_diff_low  <= i_cfg_data;
                pdc_pkg::REG_DIFF_HIGH: r_diff_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output slot is free or its transfer completes
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    pdc_mul_array u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_valid),
        .i_hash_word0 (i_hash_word0),
        .i_hash_word1 (i_hash_word1),
        .i_hash_word2 (i_hash_word2),
        .i_hash_word3 (i_hash_word3),
        .i_diff_low   (r_diff_low),
        .i_diff_high  (r_diff_high),
        .o_valid      (w_mul_valid),
        .o_prods      (w_prods)
    );

    // Fold partial products into twelve 32-bit-aligned columns
    pdc_col_sum u_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mul_valid),
        .i_prods (w_prods),
        .o_valid (w_col_valid),
        .o_cols  (w_cols)
    );

    // Ripple carries across columns; last stage is the output register
    pdc_carry_pipe u_carry (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_col_valid),
        .i_cols         (w_cols),
        .o_valid        (o_valid),
        .o_meets_target (o_meets_target)
    );

    // A stall freezes the valid bits of every stage boundary
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(o_valid) && $stable(w_mul_valid) && $stable(w_col_valid))
        else $error("pipeline valid moved during stall");

    // An accepted hash reaches the output once further advances carry it through every stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 w_en ##1 w_en ##1 w_en ##1 w_en |=> o_valid)
        else $error("accepted hash did not reach the output");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !w_mul_valid && !w_col_valid)
        else $error("pipeline not empty after reset");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // Input transfer to earliest result transfer, per the block's pipeline.
    localparam int PIPE_LATENCY = 5;
    // Receiver hold-off long enough to back the pipe up into the input.
    localparam int LONG_HOLD    = 300;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 188;

    // Handy operands for the directed rows.
    localparam logic [127:0] D_MAX     = {128{1'b1}};
    localparam logic [127:0] D_LOW_MAX = {64'd0, {64{1'b1}}};
    localparam logic [127:0] D_2P64    = 128'd1 << 64;
    localparam logic [127:0] D_2P127   = 128'd1 << 127;
    localparam logic [127:0] D_CROSS   = 128'h0000_0000_0000_0001_8000_0000_0000_0000;
    localparam logic [127:0] D_MIXED   = 128'hFEDC_BA98_7654_3210_0123_4567_89AB_CDEF;
    localparam logic [255:0] H_MAX     = {256{1'b1}};
    localparam logic [255:0] H_MSB     = 256'd1 << 255;
    localparam logic [255:0] H_2P128   = 256'd1 << 128;
    localparam logic [255:0] H_2P129   = 256'd1 << 129;
    localparam logic [255:0] H_2P192   = 256'd1 << 192;
    localparam logic [255:0] H_ALT     = {4{64'h5555_5555_5555_5555}};
    localparam logic [255:0] H_ALT_N   = ~H_ALT;
    localparam logic [255:0] H_MIXED   = {128'h0000_0000_0000_0000_00FF_00FF_00FF_00FF,
                                          128'h0123_4567_89AB_CDEF_F0F0_F0F0_0F0F_0F0F};

    // One directed row: difficulty in force, hash, and a hand-typed verdict when
    // known is set (otherwise the verdict comes from the product check below).
    typedef struct packed {
        logic [127:0] difficulty;
        logic [255:0] hash;
        logic         known;
        logic         verdict;
    } t_vector;

    // Rows sharing a difficulty stay together; a new difficulty costs a drain.
    localparam t_vector DIRECTED [21] = '{
        // reset difficulty is zero: everything passes
        '{128'd0,    H_MAX,             1'b1, 1'b1},
        '{128'd0,    256'd0,            1'b1, 1'b1},
        '{128'd0,    H_MSB,             1'b1, 1'b1},
        // largest difficulty: zero hash passes, anything above 2^128 + 1 fails
        '{D_MAX,     256'd0,            1'b1, 1'b1},
        '{D_MAX,     H_MAX,             1'b1, 1'b0},
        '{D_MAX,     256'd1,            1'b1, 1'b1},
        '{D_MAX,     H_2P128 + 256'd1,  1'b1, 1'b1},   // product is 2^256 - 1
        '{D_MAX,     H_2P128 + 256'd2,  1'b1, 1'b0},
        // unit difficulty: every hash passes
        '{128'd1,    H_MAX,             1'b1, 1'b1},
        // product exactly on 2^256 or just below it, or either side of it
        '{128'd2,    H_MSB,             1'b1, 1'b0},
        '{128'd2,    H_MSB - 256'd1,    1'b1, 1'b1},
        '{D_2P64,    H_2P192 - 256'd1,  1'b1, 1'b1},
        '{D_2P64,    H_2P192,           1'b1, 1'b0},
        '{D_2P127,   H_2P129 - 256'd1,  1'b1, 1'b1},
        '{D_2P127,   H_2P129,           1'b1, 1'b0},
        '{D_LOW_MAX, H_2P192 + 256'd1,  1'b1, 1'b1},
        '{D_LOW_MAX, H_MAX,             1'b1, 1'b0},
        // bit patterns, verdict from the product check
        '{D_LOW_MAX, H_ALT,             1'b0, 1'b0},
        '{D_CROSS,   H_ALT_N,           1'b0, 1'b0},
        '{D_MIXED,   H_MIXED,           1'b0, 1'b0},
        // back to zero difficulty via explicit writes
        '{128'd0,    H_ALT_N,           1'b1, 1'b1}
    };

    typedef struct packed {
        logic [255:0] hash;
        logic         verdict;
    } t_check;

    logic                           i_clk;
    logic                           i_rst_n      = 1'b0;
    logic                           i_cfg_we     = 1'b0;
    logic [pdc_pkg::CFG_IDX_W-1:0]  i_cfg_index  = pdc_pkg::REG_DIFF_LOW;
    logic [pdc_pkg::CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                           i_valid      = 1'b0;
    logic                           o_ready;
    logic [pdc_pkg::WORD_W-1:0]     i_hash_word0 = '0;
    logic [pdc_pkg::WORD_W-1:0]     i_hash_word1 = '0;
    logic [pdc_pkg::WORD_W-1:0]     i_hash_word2 = '0;
    logic [pdc_pkg::WORD_W-1:0]     i_hash_word3 = '0;
    logic                           o_valid;
    logic                           i_ready      = 1'b0;
    logic                           o_meets_target;

    // Difficulty as the block holds it; only changed while the pipe is empty.
    logic [127:0] difficulty = '0;
    // Verdicts owed by the block, oldest first.
    t_check       pending_verdicts [$];
    int           verdict_count = 0;
    int           error_count   = 0;
    // Per-side stretches of back-to-back transfers.
    bit           tx_burst = 1'b0;
    bit           rx_burst = 1'b0;

    pow_difficulty_check u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_hash_word0   (i_hash_word0),
        .i_hash_word1   (i_hash_word1),
        .i_hash_word2   (i_hash_word2),
        .i_hash_word3   (i_hash_word3),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_meets_target (o_meets_target)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Full 384-bit product; passes when nothing reaches bit 256 or above.
    function automatic logic hash_meets_target(logic [255:0] hash, logic [127:0] diff);
        logic [383:0] product;
        product = 384'(hash) * 384'(diff);
        return product[383:256] == '0;
    endfunction

    function automatic int bit_len(logic [127:0] v);
        for (int k = 127; k >= 0; k--) begin
            if (v[k]) return k + 1;
        end
        return 0;
    endfunction

    // Random value of exactly n significant bits (n = 0 gives zero).
    function automatic logic [255:0] rand_bits(int n);
        logic [255:0] r;
        r = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        if (n <= 0) return '0;
        r = r >> (256 - n);
        r[n-1] = 1'b1;
        return r;
    endfunction

    // Most hashes sit near the pass/fail boundary for the current difficulty:
    // either right at floor((2^256 - 1) / d) give or take two, or with a bit
    // length that puts the product close to 2^256. The rest is word noise.
    function automatic logic [255:0] random_hash(logic [127:0] diff);
        logic [255:0] limit;
        logic [257:0] probe;
        logic [255:0] noise;
        int           shape;
        int           n;
        shape = $urandom_range(0, 9);
        if (diff != '0 && shape < 4) begin
            limit = H_MAX / 256'(diff);
            probe = 258'(limit) + 258'($urandom_range(0, 4));
            probe = (probe < 258'd2) ? '0 : probe - 258'd2;
            if (probe > 258'(H_MAX)) probe = 258'(H_MAX);
            return probe[255:0];
        end
        if (shape < 8) begin
            n = 256 - bit_len(diff) + $urandom_range(0, 2) - 1;
            if (n < 0) n = 0;
            if (n > 256) n = 256;
            return rand_bits(n);
        end
        for (int w = 0; w < 4; w++) begin
            case ($urandom_range(0, 2))
                0: noise[w*64 +: 64] = '0;
                1: noise[w*64 +: 64] = '1;
                default: noise[w*64 +: 64] = {$urandom, $urandom};
            endcase
        end
        return noise;
    endfunction

    // Offer one hash; valid holds with a steady payload until the transfer.
    task automatic send_hash(input logic [255:0] hash, input logic verdict);
        int     gap;
        t_check owed;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hash_word0 <= hash[63:0];
        i_hash_word1 <= hash[127:64];
        i_hash_word2 <= hash[191:128];
        i_hash_word3 <= hash[255:192];
        do @(posedge i_clk); while (o_ready !== 1'b1);
        owed.hash    = hash;
        owed.verdict = verdict;
        pending_verdicts.push_back(owed);
    endtask

    // Stop offering, wait for every owed verdict, then let the pipe go quiet.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(negedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes, dropped once after.
    task automatic write_reg(input logic [pdc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Only the halves that change get written, so single writes are covered too.
    task automatic program_difficulty(input logic [127:0] diff);
        drain_pipeline();
        if (diff[63:0] != difficulty[63:0]) begin
            write_reg(pdc_pkg::REG_DIFF_LOW, diff[63:0]);
            difficulty[63:0] = diff[63:0];
        end
        if (diff[127:64] != difficulty[127:64]) begin
            write_reg(pdc_pkg::REG_DIFF_HIGH, diff[127:64]);
            difficulty[127:64] = diff[127:64];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic flag_error(input string msg);
        if (error_count < 10) $display("%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Stimulus: directed table first, then random phases, one difficulty each.
    initial begin : hash_source
        logic [127:0] next_diff;
        logic [255:0] hash;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].difficulty != difficulty) begin
                program_difficulty(DIRECTED[k].difficulty);
            end
            send_hash(DIRECTED[k].hash, DIRECTED[k].known ? DIRECTED[k].verdict
                      : hash_meets_target(DIRECTED[k].hash, difficulty));
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: next_diff = D_MAX;
                1: next_diff = '0;
                2: next_diff = 128'd1;
                3: next_diff = D_2P127;
                default: next_diff = 128'(rand_bits($urandom_range(1, 128)));
            endcase
            program_difficulty(next_diff);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
                hash = random_hash(difficulty);
                send_hash(hash, hash_meets_target(hash, difficulty));
            end
        end

        // Drain also waits out the pipeline; a stray late verdict is flagged.
        drain_pipeline();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Result side: random stalls per transfer, bursts with none, and two long
    // hold-offs while the source keeps offering, so o_ready must drop.
    initial begin : verdict_sink
        int stall;
        int taken;
        int holds;
        taken = 0;
        holds = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (holds < 2 && verdict_count >= 400 + 900 * holds) begin
                stall = LONG_HOLD;
                holds++;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            taken++;
        end
    end

    // Each result transfer is matched against the oldest owed verdict.
    always @(posedge i_clk) begin : verdict_check
        t_check owed;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_error($sformatf("unexpected result, meets_target=%b", o_meets_target));
            end else begin
                owed = pending_verdicts.pop_front();
                if (o_meets_target !== owed.verdict) begin
                    flag_error($sformatf("meets_target exp %b got %b, hash %h diff %h",
                                         owed.verdict, o_meets_target, owed.hash,
                                         difficulty));
                end
            end
            verdict_count++;
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin : run_limit
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
